/* sv/mvts_pkg.sv */
// ----------------------------------------------------------------------------
// mvts_pkg
// Types, codes and constants shared by the valve travel sequencer modules.
// ----------------------------------------------------------------------------
package mvts_pkg;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_OPEN  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    // power command codes
    localparam logic [1:0] PWR_NONE = 2'd0;
    localparam logic [1:0] PWR_ON   = 2'd1;
    localparam logic [1:0] PWR_OFF  = 2'd2;

    // move direction codes
    localparam logic [1:0] DIR_STOP  = 2'd0;
    localparam logic [1:0] DIR_OPEN  = 2'd1;
    localparam logic [1:0] DIR_CLOSE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_STALL_LIMIT = 2'd0;
    localparam logic [1:0] CFG_MIN_STEP    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int LIMIT_W    = 13;
    localparam int STEP_W     = 16;
    localparam int TIMEOUT_W  = 20;
    localparam int SAMPLE_W   = 12;
    localparam int ENC_W      = 32;
    localparam int ELAPSED_W  = 32;
    localparam int SPEED_W    = 7;
    // sample * 5000 and 4095 * (limit + 1) both fit here
    localparam int THRESH_W   = 26;

    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 13'd2000;
    localparam logic [STEP_W-1:0]    STEP_RST    = 16'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd10000;

    localparam logic [ELAPSED_W-1:0] TICK_MS     = 32'd50;
    localparam logic [ELAPSED_W-1:0] SETTLE_MS   = 32'd100;
    localparam logic [ELAPSED_W-1:0] BLANK_MS    = 32'd500;
    localparam logic [SPEED_W-1:0]   START_SPEED = 7'd20;
    localparam logic [SPEED_W-1:0]   SPEED_STEP  = 7'd5;
    localparam logic [SPEED_W-1:0]   FULL_SPEED  = 7'd100;
    localparam logic [SPEED_W-1:0]   CHECK_SPEED = 7'd50;
    localparam logic [THRESH_W-1:0]  ADC_FULL_MA   = 26'd5000;
    localparam logic [THRESH_W-1:0]  ADC_FULL_CODE = 26'd4095;

    // 4095 * (2000 + 1)
    localparam logic [THRESH_W-1:0] THRESH_RST = 26'd8194095;

    typedef enum logic [2:0] {
        PH_IDLE_CLOSED = 3'd0,
        PH_PRE_OPEN    = 3'd1,
        PH_OPENING     = 3'd2,
        PH_IDLE_OPEN   = 3'd3,
        PH_PRE_CLOSE   = 3'd4,
        PH_CLOSING     = 3'd5,
        PH_FAULT       = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0]          operation;
        logic                driver_fault;
        logic [SAMPLE_W-1:0] current_sample;
        logic [ENC_W-1:0]    encoder_count;
    } t_in;

    typedef struct packed {
        logic [2:0]         valve_state;
        logic [1:0]         power_command;
        logic               move_issued;
        logic [1:0]         move_direction;
        logic [SPEED_W-1:0] move_speed;
        logic               brake_engage;
        logic               encoder_clear;
    } t_out;

    // configuration as seen by the sequencing logic
    typedef struct packed {
        logic [THRESH_W-1:0]  cur_thresh;   // raw*5000 at or above this is over-current
        logic [STEP_W-1:0]    min_step;
        logic [TIMEOUT_W-1:0] timeout_ms;
    } t_cfg;

endpackage

/* sv/motor_valve_travel_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// motor_valve_travel_sequencer_unit
// Valve motor open/close sequencer with soft start, stall and timeout checks.
// ----------------------------------------------------------------------------
// Takes one item (tick or command) per clock while the input is not stalled and
// returns one result per item. An item passes an input register and then a result
// register; the sequencer state is updated in the single compute stage between
// them, which is what allows a new item every cycle when the output is not stalled.
// Input stall rises only when both registers hold items and the output is
// stalled. Config writes take effect at once and belong to idle periods.
module motor_valve_travel_sequencer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mvts_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mvts_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [mvts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mvts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                               r_in_vld;
    mvts_pkg::t_in                      r_in;
    logic                               r_out_vld;
    mvts_pkg::t_out                     r_out;
    logic [mvts_pkg::THRESH_W-1:0]      r_thresh, n_thresh;
    logic [mvts_pkg::STEP_W-1:0]        r_min_step;
    logic [mvts_pkg::TIMEOUT_W-1:0]     r_timeout;
    logic                               out_free, fire, in_take;
    mvts_pkg::t_cfg                     cfg;
    mvts_pkg::t_out                     result;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // over-current threshold kept in raw*5000 units
    assign n_thresh = (mvts_pkg::THRESH_W'(i_cfg_data[mvts_pkg::LIMIT_W-1:0]) + 1'b1)
                      * mvts_pkg::ADC_FULL_CODE;

    assign cfg.cur_thresh = r_thresh;
    assign cfg.min_step   = r_min_step;
    assign cfg.timeout_ms = r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh   <= mvts_pkg::THRESH_RST;
            r_min_step <= mvts_pkg::STEP_RST;
            r_timeout  <= mvts_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mvts_pkg::CFG_STALL_LIMIT: r_thresh   <= n_thresh;
                mvts_pkg::CFG_MIN_STEP:    r_min_step <= i_cfg_data[mvts_pkg::STEP_W-1:0];
                mvts_pkg::CFG_TIMEOUT:     r_timeout  <= i_cfg_data[mvts_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    mvts_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

endmodule

/* sv/mvts_core.sv */
// ----------------------------------------------------------------------------
// mvts_core
// Sequencer state and the one-pass next-state / result logic for one item.
// ----------------------------------------------------------------------------
module mvts_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  mvts_pkg::t_in  i_item,
    input  mvts_pkg::t_cfg i_cfg,
    output mvts_pkg::t_out o_result
);

    mvts_pkg::t_phase               r_phase, n_phase;
    logic [mvts_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [mvts_pkg::ENC_W-1:0]     r_prev_enc, n_prev_enc;
    logic [mvts_pkg::SPEED_W-1:0]   r_speed, n_speed;

    logic                           is_tick, is_cmd, idle, pre, travel, opening;
    logic [mvts_pkg::ELAPSED_W-1:0] elapsed_inc;
    logic                           below_full;
    logic [mvts_pkg::SPEED_W-1:0]   speed_up, travel_speed;
    logic                           timed_out, blank_over, over_current;
    logic                           enc_check, stalled;
    logic [mvts_pkg::ENC_W-1:0]     enc_adv;
    logic [mvts_pkg::THRESH_W-1:0]  sample_scaled;

    assign is_tick = (i_item.operation == mvts_pkg::OP_TICK);
    assign is_cmd  = (i_item.operation == mvts_pkg::OP_OPEN) ||
                     (i_item.operation == mvts_pkg::OP_CLOSE);
    assign idle    = (r_phase == mvts_pkg::PH_IDLE_CLOSED) ||
                     (r_phase == mvts_pkg::PH_IDLE_OPEN);
    assign pre     = (r_phase == mvts_pkg::PH_PRE_OPEN) ||
                     (r_phase == mvts_pkg::PH_PRE_CLOSE);
    assign travel  = (r_phase == mvts_pkg::PH_OPENING) ||
                     (r_phase == mvts_pkg::PH_CLOSING);
    assign opening = (r_phase == mvts_pkg::PH_OPENING);

    // saturating tick timer
    assign elapsed_inc = (r_elapsed > ('1 - mvts_pkg::TICK_MS)) ? '1
                                                                : r_elapsed + mvts_pkg::TICK_MS;

    assign below_full   = (r_speed < mvts_pkg::FULL_SPEED);
    assign speed_up     = r_speed + mvts_pkg::SPEED_STEP;
    assign travel_speed = below_full ? speed_up : r_speed;

    assign timed_out  = (elapsed_inc > mvts_pkg::ELAPSED_W'(i_cfg.timeout_ms));
    assign blank_over = (elapsed_inc > mvts_pkg::BLANK_MS);

    // mA > limit  <=>  raw*5000 >= 4095*(limit+1)
    assign sample_scaled = mvts_pkg::THRESH_W'(i_item.current_sample) * mvts_pkg::ADC_FULL_MA;
    assign over_current  = (sample_scaled >= i_cfg.cur_thresh);

    // encoder advance check uses the speed after this tick's ramp step
    assign enc_check = blank_over && !over_current && (travel_speed > mvts_pkg::CHECK_SPEED);
    assign enc_adv   = i_item.encoder_count - r_prev_enc;
    assign stalled   = blank_over &&
                       (over_current ||
                        (enc_check && (enc_adv < mvts_pkg::ENC_W'(i_cfg.min_step))));

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_prev_enc = r_prev_enc;
        n_speed    = r_speed;
        if (is_cmd) begin
            if (idle) begin
                n_phase   = (i_item.operation == mvts_pkg::OP_OPEN) ? mvts_pkg::PH_PRE_OPEN
                                                                    : mvts_pkg::PH_PRE_CLOSE;
                n_elapsed = '0;
            end
        end else if (is_tick) begin
            n_elapsed = elapsed_inc;
            if (i_item.driver_fault) begin
                n_phase = mvts_pkg::PH_FAULT;
            end else if (pre) begin
                n_prev_enc = '0;
                n_speed    = mvts_pkg::START_SPEED;
                if (elapsed_inc > mvts_pkg::SETTLE_MS) begin
                    n_phase   = (r_phase == mvts_pkg::PH_PRE_OPEN) ? mvts_pkg::PH_OPENING
                                                                   : mvts_pkg::PH_CLOSING;
                    n_elapsed = '0;
                end
            end else if (travel) begin
                n_speed = travel_speed;
                if (enc_check) begin
                    n_prev_enc = i_item.encoder_count;
                end
                if (stalled) begin
                    n_phase = opening ? mvts_pkg::PH_IDLE_OPEN : mvts_pkg::PH_IDLE_CLOSED;
                end else if (timed_out) begin
                    n_phase = mvts_pkg::PH_FAULT;
                end
            end
        end
    end

    // result fields
    always_comb begin
        o_result             = '0;
        o_result.valve_state = n_phase;
        if (is_tick) begin
            if (i_item.driver_fault) begin
                o_result.power_command = mvts_pkg::PWR_OFF;
            end else if (pre) begin
                o_result.power_command = mvts_pkg::PWR_ON;
                o_result.encoder_clear = 1'b1;
            end else if (travel) begin
                o_result.move_issued = below_full || timed_out;
                if (below_full && !timed_out) begin
                    o_result.move_direction = opening ? mvts_pkg::DIR_OPEN
                                                      : mvts_pkg::DIR_CLOSE;
                    o_result.move_speed     = speed_up;
                end
                if (timed_out || stalled) begin
                    o_result.power_command = mvts_pkg::PWR_OFF;
                end
                o_result.brake_engage = stalled;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= mvts_pkg::PH_IDLE_CLOSED;
            r_elapsed  <= '0;
            r_prev_enc <= '0;
            r_speed    <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_elapsed  <= n_elapsed;
            r_prev_enc <= n_prev_enc;
            r_speed    <= n_speed;
        end
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the valve motor travel sequencer. Open and close
// travels with random timing, noise items and several register settings are
// sent through the block. Every result is checked against a cycle-free
// model of the sequencer. The run ends in the fault state, because that
// state can only be left by reset.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // operation code the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1120;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    mvts_pkg::t_in                   in_item = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    mvts_pkg::t_out                  out_item;
    logic                            cfg_we = 1'b0;
    logic [mvts_pkg::CFG_IDX_W-1:0]  cfg_idx = mvts_pkg::CFG_STALL_LIMIT;
    logic [mvts_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    motor_valve_travel_sequencer_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // sequencer model state and its copy of the registers
    mvts_pkg::t_phase             seq_phase;
    logic [31:0]                  seq_elapsed;
    logic [31:0]                  seq_prev_enc;
    logic [mvts_pkg::SPEED_W-1:0] seq_speed;
    logic [12:0]                  cfg_limit;
    logic [15:0]                  cfg_min_step;
    logic [19:0]                  cfg_timeout;

    mvts_pkg::t_in  valve_items[$];
    mvts_pkg::t_out due_outputs[$];

    logic [31:0] enc_track;        // encoder value last queued for the current travel
    bit          jitter_on = 1'b0;
    int unsigned items_queued = 0;
    int unsigned items_driven = 0;
    int unsigned results_seen = 0;
    int unsigned travels = 0;
    int unsigned settings_used = 1;
    int unsigned err_count = 0;
    bit          end_by_pin;

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("tb_top: ERROR: %s", msg);
    endtask

    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one item through the sequencer: updates model state, returns the result
    function automatic mvts_pkg::t_out sequence_valve(input mvts_pkg::t_in it);
        mvts_pkg::t_out res;
        logic           opening;
        logic           stalled;
        int unsigned    load_ma;
        logic [31:0]    advance;
        res = '0;
        if (it.operation == mvts_pkg::OP_OPEN || it.operation == mvts_pkg::OP_CLOSE) begin
            if (seq_phase == mvts_pkg::PH_IDLE_CLOSED || seq_phase == mvts_pkg::PH_IDLE_OPEN) begin
                if (it.operation == mvts_pkg::OP_OPEN)
                    seq_phase = mvts_pkg::PH_PRE_OPEN;
                else
                    seq_phase = mvts_pkg::PH_PRE_CLOSE;
                seq_elapsed = '0;
            end
        end else if (it.operation == mvts_pkg::OP_TICK) begin
            if (seq_elapsed > 32'hFFFF_FFFF - mvts_pkg::TICK_MS)
                seq_elapsed = 32'hFFFF_FFFF;
            else
                seq_elapsed = seq_elapsed + mvts_pkg::TICK_MS;
            if (it.driver_fault) begin
                res.power_command = mvts_pkg::PWR_OFF;
                seq_phase = mvts_pkg::PH_FAULT;
            end else if (seq_phase == mvts_pkg::PH_PRE_OPEN ||
                         seq_phase == mvts_pkg::PH_PRE_CLOSE) begin
                res.power_command = mvts_pkg::PWR_ON;
                res.encoder_clear = 1'b1;
                seq_prev_enc = '0;
                seq_speed = mvts_pkg::START_SPEED;
                if (seq_elapsed > mvts_pkg::SETTLE_MS) begin
                    if (seq_phase == mvts_pkg::PH_PRE_OPEN)
                        seq_phase = mvts_pkg::PH_OPENING;
                    else
                        seq_phase = mvts_pkg::PH_CLOSING;
                    seq_elapsed = '0;
                end
            end else if (seq_phase == mvts_pkg::PH_OPENING ||
                         seq_phase == mvts_pkg::PH_CLOSING) begin
                opening = (seq_phase == mvts_pkg::PH_OPENING);
                if (seq_speed < mvts_pkg::FULL_SPEED) begin
                    seq_speed = seq_speed + mvts_pkg::SPEED_STEP;
                    res.move_issued = 1'b1;
                    res.move_direction = opening ? mvts_pkg::DIR_OPEN : mvts_pkg::DIR_CLOSE;
                    res.move_speed = seq_speed;
                end
                if (seq_elapsed > cfg_timeout) begin
                    seq_phase = mvts_pkg::PH_FAULT;
                    res.move_issued = 1'b1;
                    res.move_direction = mvts_pkg::DIR_STOP;
                    res.move_speed = '0;
                    res.power_command = mvts_pkg::PWR_OFF;
                end
                // stall check only after inrush blanking
                if (seq_elapsed > mvts_pkg::BLANK_MS) begin
                    stalled = 1'b0;
                    load_ma = 32'((it.current_sample * mvts_pkg::ADC_FULL_MA)
                                  / mvts_pkg::ADC_FULL_CODE);
                    if (load_ma > cfg_limit) begin
                        stalled = 1'b1;
                    end else if (seq_speed > mvts_pkg::CHECK_SPEED) begin
                        advance = it.encoder_count - seq_prev_enc;
                        seq_prev_enc = it.encoder_count;
                        if (advance < cfg_min_step)
                            stalled = 1'b1;
                    end
                    if (stalled) begin
                        res.brake_engage = 1'b1;
                        res.power_command = mvts_pkg::PWR_OFF;
                        seq_phase = opening ? mvts_pkg::PH_IDLE_OPEN : mvts_pkg::PH_IDLE_CLOSED;
                    end
                end
            end
        end
        res.valve_state = seq_phase;
        return res;
    endfunction

    // sender: presents queued items, random gaps after each one while jitter is on
    always @(posedge clk) begin : tx_side
        int unsigned send_gap;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                due_outputs.push_back(sequence_valve(in_item));
                items_driven++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap--;
                end else if (valve_items.size() > 0) begin
                    in_valid <= 1'b1;
                    in_item <= valve_items.pop_front();
                    send_gap = jitter_on ? gap_len() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks results, random stalls plus up to two long hold-offs
    always @(posedge clk) begin : rx_side
        mvts_pkg::t_out want;
        int unsigned    rx_gap;
        int unsigned    rx_hold;
        int unsigned    long_holds;
        int unsigned    n;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_gap = 0;
            rx_hold = 0;
            long_holds = 0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (due_outputs.size() == 0) begin
                    flag_error($sformatf("result %h with no item outstanding", out_item));
                end else begin
                    want = due_outputs.pop_front();
                    if (out_item.valve_state !== want.valve_state)
                        flag_error($sformatf("result %0d valve_state %0d, want %0d",
                            results_seen, out_item.valve_state, want.valve_state));
                    if (out_item.power_command !== want.power_command)
                        flag_error($sformatf("result %0d power_command %0d, want %0d",
                            results_seen, out_item.power_command, want.power_command));
                    if (out_item.move_issued !== want.move_issued)
                        flag_error($sformatf("result %0d move_issued %0d, want %0d",
                            results_seen, out_item.move_issued, want.move_issued));
                    if (out_item.move_direction !== want.move_direction)
                        flag_error($sformatf("result %0d move_direction %0d, want %0d",
                            results_seen, out_item.move_direction, want.move_direction));
                    if (out_item.move_speed !== want.move_speed)
                        flag_error($sformatf("result %0d move_speed %0d, want %0d",
                            results_seen, out_item.move_speed, want.move_speed));
                    if (out_item.brake_engage !== want.brake_engage)
                        flag_error($sformatf("result %0d brake_engage %0d, want %0d",
                            results_seen, out_item.brake_engage, want.brake_engage));
                    if (out_item.encoder_clear !== want.encoder_clear)
                        flag_error($sformatf("result %0d encoder_clear %0d, want %0d",
                            results_seen, out_item.encoder_clear, want.encoder_clear));
                end
            end
            // long hold-off while the sender still has plenty to offer
            if (rx_hold == 0 && long_holds < 2 && results_seen >= 300 + 450 * long_holds
                && valve_items.size() > 16) begin
                rx_hold = 60;
                long_holds++;
            end
            if (rx_hold > 0) begin
                out_stall <= 1'b1;
                rx_hold--;
            end else if (rx_gap > 0) begin
                out_stall <= 1'b1;
                rx_gap--;
            end else if (jitter_on) begin
                n = gap_len();
                out_stall <= (n > 0);
                rx_gap = (n > 0) ? n - 1 : 0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_item(input logic [1:0] op, input logic fault,
                             input logic [11:0] sample, input logic [31:0] enc);
        mvts_pkg::t_in it;
        it.operation = op;
        it.driver_fault = fault;
        it.current_sample = sample;
        it.encoder_count = enc;
        valve_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_any_tick();
        push_item(mvts_pkg::OP_TICK, 1'b0, 12'($urandom_range(0, 4095)), $urandom());
    endtask

    // ignored items; commands only where the block is not idle
    task automatic maybe_noise(input bit allow_cmd);
        logic [1:0] op;
        if ($urandom_range(0, 5) == 0) begin
            op = allow_cmd ? 2'($urandom_range(1, 3)) : OP_UNUSED;
            push_item(op, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)), $urandom());
        end
    endtask

    // largest converter sample that stays at or under the current limit
    function automatic int unsigned safe_sample_max();
        int unsigned m;
        m = ((int'(cfg_limit) + 1) * 4095 - 1) / 5000;
        return (m > 4095) ? 4095 : m;
    endfunction

    task automatic queue_travel_tick(input int unsigned k, input bit stop);
        int unsigned ok_max;
        logic [31:0] adv;
        bit          by_current;
        ok_max = safe_sample_max();
        if (k <= 10) begin
            // still blanked, anything goes
            push_any_tick();
        end else if (!stop) begin
            if ($urandom_range(0, 3) == 0)
                adv = cfg_min_step + $urandom_range(0, 32'h7FFF_FFFF);
            else
                adv = cfg_min_step + $urandom_range(0, 300);
            enc_track = enc_track + adv;
            push_item(mvts_pkg::OP_TICK, 1'b0, 12'($urandom_range(0, ok_max)), enc_track);
        end else begin
            if (cfg_limit >= 5000)
                by_current = 1'b0;
            else if (cfg_min_step == 0)
                by_current = 1'b1;
            else
                by_current = 1'($urandom_range(0, 1));
            if (by_current) begin
                push_item(mvts_pkg::OP_TICK, 1'b0, 12'($urandom_range(ok_max + 1, 4095)),
                          $urandom());
            end else begin
                enc_track = enc_track + $urandom_range(0, cfg_min_step - 1);
                push_item(mvts_pkg::OP_TICK, 1'b0, 12'($urandom_range(0, ok_max)), enc_track);
            end
        end
    endtask

    // command, pre-phase, travel that ends in a stall before or at the timeout
    task automatic queue_travel();
        int unsigned stop_at;
        logic [1:0]  cmd;
        cmd = ($urandom_range(0, 1) == 0) ? mvts_pkg::OP_OPEN : mvts_pkg::OP_CLOSE;
        push_item(cmd, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)), $urandom());
        for (int k = 0; k < 3; k++) begin
            maybe_noise(1'b1);
            push_any_tick();
        end
        enc_track = '0;
        stop_at = cfg_timeout / 50 + 1;
        if (stop_at > 36)
            stop_at = 36;
        stop_at = $urandom_range(11, stop_at);
        for (int k = 1; k <= stop_at; k++) begin
            maybe_noise(1'b1);
            queue_travel_tick(k, k == stop_at);
        end
        repeat ($urandom_range(0, 3)) begin
            maybe_noise(1'b0);
            push_any_tick();
        end
        travels++;
    endtask

    task automatic write_reg(input logic [mvts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mvts_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            mvts_pkg::CFG_STALL_LIMIT: cfg_limit = val[12:0];
            mvts_pkg::CFG_MIN_STEP:    cfg_min_step = val[15:0];
            mvts_pkg::CFG_TIMEOUT:     cfg_timeout = val[19:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (valve_items.size() != 0 || in_valid || due_outputs.size() != 0);
    endtask

    initial begin : stimulus
        int unsigned phase_no;
        int unsigned phase_start;
        logic [12:0] lim;
        logic [15:0] step;
        logic [19:0] tmo;
        seq_phase = mvts_pkg::PH_IDLE_CLOSED;
        seq_elapsed = '0;
        seq_prev_enc = '0;
        seq_speed = '0;
        cfg_limit = mvts_pkg::LIMIT_RST;
        cfg_min_step = mvts_pkg::STEP_RST;
        cfg_timeout = mvts_pkg::TIMEOUT_RST;
        enc_track = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset register values, ignored items, one closing travel, then three random travels
        push_item(OP_UNUSED, 1'b1, 12'hFFF, 32'hFFFF_FFFF);
        push_item(mvts_pkg::OP_TICK, 1'b0, 12'hFFF, 32'hFFFF_FFFF);
        push_item(mvts_pkg::OP_TICK, 1'b0, 12'h000, 32'h0);
        push_item(mvts_pkg::OP_CLOSE, 1'b1, 12'h000, 32'h0);
        push_item(mvts_pkg::OP_OPEN, 1'b0, 12'hFFF, 32'hFFFF_FFFF);
        push_item(mvts_pkg::OP_TICK, 1'b0, 12'hFFF, 32'h0);
        push_item(mvts_pkg::OP_TICK, 1'b0, 12'h000, 32'hFFFF_FFFF);
        push_item(mvts_pkg::OP_TICK, 1'b0, 12'h4D2, 32'h1234_5678);
        // over-current during blanking does not count
        for (int k = 1; k <= 10; k++)
            push_item(mvts_pkg::OP_TICK, 1'b0, 12'hFFF, $urandom());
        // encoder advanced by 5 at speed 75: stall
        push_item(mvts_pkg::OP_TICK, 1'b0, 12'h000, 32'd5);
        repeat (3) queue_travel();
        wait_drained();

        phase_no = 1;
        while (items_queued < ITEM_TARGET) begin
            case (phase_no)
                1: begin lim = 13'd0;    step = 16'd0;     tmo = 20'd600000; end
                2: begin lim = 13'd5000; step = 16'd65535; tmo = 20'd500;    end
                3: begin lim = 13'd4999; step = 16'd1;     tmo = 20'd600;    end
                default: begin
                    lim = 13'($urandom_range(0, 5000));
                    step = 16'($urandom_range(0, 65535));
                    tmo = 20'($urandom_range(500, 3000));
                    if (lim == 13'd5000 && step == 16'd0)
                        step = 16'd1;
                end
            endcase
            write_reg(mvts_pkg::CFG_STALL_LIMIT, mvts_pkg::CFG_DATA_W'(lim));
            write_reg(mvts_pkg::CFG_MIN_STEP, mvts_pkg::CFG_DATA_W'(step));
            write_reg(mvts_pkg::CFG_TIMEOUT, mvts_pkg::CFG_DATA_W'(tmo));
            settings_used++;
            @(negedge clk);
            jitter_on = (phase_no % 3 != 0);
            phase_start = items_queued;
            while (items_queued - phase_start < 180 && items_queued < ITEM_TARGET)
                queue_travel();
            wait_drained();
            phase_no++;
        end

        // ending: fault has no exit, so it comes last
        jitter_on = 1'b1;
        end_by_pin = 1'($urandom_range(0, 1));
        if (end_by_pin) begin
            push_item(mvts_pkg::OP_OPEN, 1'b0, 12'($urandom_range(0, 4095)), $urandom());
            repeat ($urandom_range(1, 13)) push_any_tick();
            push_item(mvts_pkg::OP_TICK, 1'b1, 12'($urandom_range(0, 4095)), $urandom());
            wait_drained();
            write_reg(mvts_pkg::CFG_TIMEOUT, '0);
            @(negedge clk);
        end else begin
            write_reg(mvts_pkg::CFG_TIMEOUT, '0);
            @(negedge clk);
            push_item(mvts_pkg::OP_CLOSE, 1'b0, 12'($urandom_range(0, 4095)), $urandom());
            repeat (6) push_any_tick();
        end
        repeat (24)
            push_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      12'($urandom_range(0, 4095)), $urandom());
        wait_drained();
        repeat (6) @(posedge clk);

        if (due_outputs.size() != 0)
            flag_error($sformatf("%0d results never arrived", due_outputs.size()));
        $display("tb_top: %0d items, %0d results checked, %0d travels over %0d register settings",
                 items_driven, results_seen, travels, settings_used);
        $display("tb_top: fault entered by %s", end_by_pin ? "driver fault pin" : "travel timeout");
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* files.f */
sv/mvts_pkg.sv
sv/mvts_core.sv
sv/motor_valve_travel_sequencer_unit.sv
tb/tb_top.sv
